// File: hw/rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked while out of reset
`define HPB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hpb assertion failed");
// property checked at every edge
`define HPB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("hpb assertion failed");
`else
`define HPB_ASSERT(name, clk, rst, prop)
`define HPB_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: hw/rtl/hpb_pkg.sv
package hpb_pkg;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [11:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [11:0] highest_prio;
      logic        bitmap_empty;
      logic        is_marked;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic rd_item;
      logic update;
      logic walk1;
      logic walk2;
      logic finish;
      logic clr_wr;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_done;
      logic out_free;
   } status_type;

   // index of the lowest set bit, 0 for zero
   function automatic logic [2:0] low_bit(input logic [7:0] v);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/hierarchical_priority_bitmap.sv
// Four-level eight-way priority bitmap over up to 4096 priorities.
// Request channel (req_valid, req_stall, req_data) carries an opcode
// (set, clear, test, find) and a priority. Response channel (rsp_valid,
// rsp_stall, rsp_data) returns one transaction per request: the lowest
// marked priority, an empty flag and, for test, the marked flag.
// Each request passes from acceptance to the response register through
// a memory read of the level-two and leaf bytes, an update step, and a
// three-step lowest-set-bit walk down the levels, whose two lower
// levels sit in single-port memories with registered reads.
// A new request is accepted only after the previous one finishes its walk.
// After reset a clearing pass writes zero to the 512 leaf bytes and the
// 64 level-two bytes, with req_stall high throughout.
// When the receiver stalls, the response is held in the output register;
// the next request is still accepted and waits at the end of its walk
// until the output register frees.
// Priorities at or above PRIO_COUNT leave the bitmap unchanged.
module hierarchical_priority_bitmap #(
   parameter int PRIO_COUNT = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpb_pkg::rsp_type rsp_data
);
   import hpb_pkg::*;

`include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;

   hpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hpb_dp #(
      .PRIO_COUNT (PRIO_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a new response comes only from the walk completing
   `HPB_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid) |-> $past(cmd.finish))
   // never overwrite a stalled response
   `HPB_ASSERT(a_no_overwrite, clock, reset, cmd.finish |-> !(rsp_valid && rsp_stall))
   // empty bitmap reports priority zero
   `HPB_ASSERT(a_empty_zero, clock, reset,
      rsp_valid |-> (!rsp_data.bitmap_empty || rsp_data.highest_prio == 12'd0))
   // no request taken during the clearing pass
   `HPB_ASSERT_ALWAYS(a_clear_blocks, clock, cmd.clr_wr |-> req_stall)

endmodule

// File: hw/rtl/hpb_ctrl.sv
module hpb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hpb_pkg::status_type status,
   output hpb_pkg::cmd_type    cmd
);
   import hpb_pkg::*;

   typedef enum logic [6:0] {
      ST_CLR  = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_RD   = 7'b0000100,
      ST_UPD  = 7'b0001000,
      ST_W1   = 7'b0010000,
      ST_W2   = 7'b0100000,
      ST_W3   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_item = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_W1;
         end
         ST_W1: begin
            cmd.walk1 = 1'b1;
            state_in  = ST_W2;
         end
         ST_W2: begin
            cmd.walk2 = 1'b1;
            state_in  = ST_W3;
         end
         ST_W3: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/hpb_dp.sv
module hpb_dp #(
   parameter int PRIO_COUNT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  hpb_pkg::req_type    req_data,
   input  hpb_pkg::cmd_type    cmd,
   output hpb_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hpb_pkg::rsp_type    rsp_data
);
   import hpb_pkg::*;

   req_type     req_ff;
   logic [8:0]  clr_cnt_ff;
   logic [7:0]  root_ff, root_in;
   logic [7:0]  l1_ff [8];
   logic [7:0]  l2_mem [64];
   logic [7:0]  leaf_mem [512];
   logic [7:0]  l2_q_ff, leaf_q_ff;
   logic [2:0]  d1_ff, d2_ff, d3_ff;
   logic        marked_ff, marked_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [11:0] prio;
   logic [2:0]  g1;
   logic [5:0]  g2;
   logic [8:0]  g3;
   logic [7:0]  b1, b2, b3, b4;
   logic        in_range, wr_item;
   logic [2:0]  d1, d2w, d3w;
   logic [2:0]  l1_idx;
   logic [7:0]  l1_rd, l1_new;
   logic [7:0]  l2_new, leaf_new;
   logic [5:0]  l2_raddr, l2_waddr;
   logic [8:0]  leaf_raddr, leaf_waddr;
   logic [7:0]  l2_wdata, leaf_wdata;
   logic        l2_we, leaf_we;

   // priority digits and one-hot masks
   assign prio     = req_ff.priority_req;
   assign g1       = prio[11:9];
   assign g2       = prio[11:6];
   assign g3       = prio[11:3];
   assign b1       = 8'd1 << prio[11:9];
   assign b2       = 8'd1 << prio[8:6];
   assign b3       = 8'd1 << prio[5:3];
   assign b4       = 8'd1 << prio[2:0];
   assign in_range = {1'b0, prio} < 13'(PRIO_COUNT);
   assign wr_item  = cmd.update && in_range &&
                     (req_ff.opcode == OP_SET || req_ff.opcode == OP_CLEAR);

   // level-one byte, one read address
   assign d1     = low_bit(root_ff);
   assign l1_idx = cmd.update ? g1 : d1;
   assign l1_rd  = l1_ff[l1_idx];
   assign d2w    = low_bit(l1_rd);
   assign d3w    = low_bit(l2_q_ff);

   // update of the four levels and the test flag
   always_comb begin
      root_in   = root_ff;
      l1_new    = l1_rd;
      l2_new    = l2_q_ff;
      leaf_new  = leaf_q_ff;
      marked_in = 1'b0;
      case (req_ff.opcode)
         OP_SET: begin
            root_in  = root_ff | b1;
            l1_new   = l1_rd | b2;
            l2_new   = l2_q_ff | b3;
            leaf_new = leaf_q_ff | b4;
         end
         OP_CLEAR: begin
            leaf_new = leaf_q_ff & ~b4;
            if (leaf_new == 8'd0) begin
               l2_new = l2_q_ff & ~b3;
               if (l2_new == 8'd0) begin
                  l1_new = l1_rd & ~b2;
                  if (l1_new == 8'd0) begin
                     root_in = root_ff & ~b1;
                  end
               end
            end
         end
         OP_TEST: begin
            marked_in = in_range && (root_ff & b1) != 8'd0 && (l1_rd & b2) != 8'd0 &&
                        (l2_q_ff & b3) != 8'd0 && (leaf_q_ff & b4) != 8'd0;
         end
         default: begin
            marked_in = 1'b0;
         end
      endcase
   end

   // memory ports
   assign l2_raddr   = cmd.rd_item ? g2 : {d1, d2w};
   assign leaf_raddr = cmd.rd_item ? g3 : {d1_ff, d2_ff, d3w};
   assign l2_waddr   = cmd.clr_wr ? clr_cnt_ff[5:0] : g2;
   assign leaf_waddr = cmd.clr_wr ? clr_cnt_ff : g3;
   assign l2_wdata   = cmd.clr_wr ? 8'd0 : l2_new;
   assign leaf_wdata = cmd.clr_wr ? 8'd0 : leaf_new;
   assign l2_we      = cmd.clr_wr || wr_item;
   assign leaf_we    = cmd.clr_wr || wr_item;

   always_ff @(posedge clock) begin
      if (l2_we) begin
         l2_mem[l2_waddr] <= l2_wdata;
      end
      if (cmd.rd_item || cmd.walk1) begin
         l2_q_ff <= l2_mem[l2_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_waddr] <= leaf_wdata;
      end
      if (cmd.rd_item || cmd.walk2) begin
         leaf_q_ff <= leaf_mem[leaf_raddr];
      end
   end

   // root, level one and clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff    <= 8'd0;
         clr_cnt_ff <= 9'd0;
         for (int i = 0; i < 8; i++) begin
            l1_ff[i] <= 8'd0;
         end
      end else begin
         if (cmd.clr_wr) begin
            clr_cnt_ff <= clr_cnt_ff + 9'd1;
         end
         if (wr_item) begin
            root_ff       <= root_in;
            l1_ff[l1_idx] <= l1_new;
         end
      end
   end

   // transaction and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.update) begin
         marked_ff <= marked_in;
      end
      if (cmd.walk1) begin
         d1_ff <= d1;
         d2_ff <= d2w;
      end
      if (cmd.walk2) begin
         d3_ff <= d3w;
      end
      if (cmd.finish) begin
         rsp_ff.bitmap_empty <= (root_ff == 8'd0);
         rsp_ff.highest_prio <= (root_ff == 8'd0) ? 12'd0 :
                                {d1_ff, d2_ff, d3_ff, low_bit(leaf_q_ff)};
         rsp_ff.is_marked    <= marked_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.clr_done = (clr_cnt_ff == 9'h1ff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule
